// ===== rtl/core/mroe_pkg.sv =====
// Package: shared types and constants for the matrix row operation engine.
`timescale 1ns / 1ps
package mroe_pkg;
    localparam int MAX_DIM_DEF = 16;

    typedef enum logic [3:0] {
        OP_WRITE  = 4'd0,
        OP_READ   = 4'd1,
        OP_TRANS  = 4'd2,
        OP_SWAPR  = 4'd3,
        OP_SWAPC  = 4'd4,
        OP_SCALE  = 4'd5,
        OP_DIVIDE = 4'd6,
        OP_ROWADD = 4'd7,
        OP_NORM   = 4'd8
    } t_op;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADIDX = 2'd1;
    localparam logic [1:0] ST_NOTSQ  = 2'd2;
    localparam logic [1:0] ST_SMALL  = 2'd3;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_MDIV = 2'd2;

    localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

    // Arithmetic unit requests and answers.
    typedef enum logic [1:0] {
        AU_MUL,
        AU_DIV
    } t_au_op;

    typedef struct packed {
        logic                start;
        t_au_op              op;
        logic signed [31:0]  a;
        logic signed [31:0]  b;
    } t_au_req;

    // quotient magnitude reaches 2^47, so one bit above 48 for the sign
    typedef struct packed {
        logic                done;
        logic signed [48:0]  res;
    } t_au_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_RD0,
        S_RD1,
        S_WAIT,
        S_CALC,
        S_AU,
        S_WR0,
        S_WR1,
        S_NEXT,
        S_RESP
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647) return SAT_MAX;
        if (v < -50'sd2147483648) return SAT_MIN;
        return v[31:0];
    endfunction
endpackage

// ===== rtl/core/mroe_arith.sv =====
// Shared arithmetic unit: Q16.16 multiply (2 stages) and radix-2 divide (48 steps).
`timescale 1ns / 1ps
module mroe_arith (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mroe_pkg::t_au_req   i_req,
    output mroe_pkg::t_au_rsp   o_rsp
);
    // Multiply: product magnitude >>16, then sign restored (truncates toward zero).
    logic signed [63:0] r_prod;
    logic               r_mbusy;
    logic               r_mneg;
    // Divide: |a|<<16 / |d|, restoring, one bit per cycle.
    logic [47:0] r_quo;
    logic [32:0] r_rem;
    logic [31:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_dbusy;
    logic        r_dneg;
    logic        r_done;
    logic signed [48:0] r_res;

    logic [31:0] w_amag;
    logic [32:0] w_trial;
    logic [63:0] w_pmag;
    logic [47:0] w_q;
    assign w_amag  = i_req.a[31] ? 32'(-i_req.a) : i_req.a;
    assign w_trial = {r_rem[31:0], r_quo[47]} - {1'b0, r_dvs};
    assign w_pmag  = r_prod[63] ? 64'(-r_prod) : r_prod;
    assign w_q     = {r_quo[46:0], ~w_trial[32]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_dbusy <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && i_req.op == mroe_pkg::AU_MUL) begin
                r_prod  <= 64'(i_req.a) * 64'(i_req.b);
                r_mbusy <= 1'b1;
            end else if (i_req.start) begin
                r_quo   <= {w_amag, 16'd0};
                r_rem   <= '0;
                r_dvs   <= i_req.b[31] ? 32'(-i_req.b) : i_req.b;
                r_dneg  <= i_req.a[31] ^ i_req.b[31];
                r_cnt   <= 6'd48;
                r_dbusy <= 1'b1;
            end
            if (r_mbusy) begin
                r_mbusy <= 1'b0;
                r_done  <= 1'b1;
                r_res   <= r_prod[63] ? -49'(w_pmag[63:16]) : 49'(w_pmag[63:16]);
            end
            if (r_dbusy) begin
                r_rem <= w_trial[32] ? {r_rem[31:0], r_quo[47]} : w_trial;
                r_quo <= w_q;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_dbusy <= 1'b0;
                    r_done  <= 1'b1;
                    r_res   <= r_dneg ? -49'(w_q) : 49'(w_q);
                end
            end
        end
    end
    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;
endmodule

// ===== rtl/core/mroe_seq.sv =====
// Sequencer and matrix store: walks elements, drives the shared arithmetic unit.
`timescale 1ns / 1ps
module mroe_seq #(
    parameter int MAX_DIM = mroe_pkg::MAX_DIM_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_go,
    output logic                   o_busy,
    input  logic [3:0]             i_op,
    input  logic [3:0]             i_index_a,
    input  logic [3:0]             i_index_b,
    input  logic signed [31:0]     i_value,
    input  logic [4:0]             i_num_rows,
    input  logic [4:0]             i_num_cols,
    input  logic [30:0]            i_min_divisor,
    output logic                   o_res_valid,
    input  logic                   i_res_stall,
    output logic [1:0]             o_status,
    output logic signed [31:0]     o_result_value
);
    localparam int DW = $clog2(MAX_DIM);
    // counters wide enough for the 5-bit sizes and 4-bit indices
    localparam int CW = (DW + 1 > 5) ? DW + 1 : 5;
    localparam int AW = 2 * DW;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    // row sum of MAX_DIM magnitudes up to 2^31 each
    localparam int SW = 33 + DW;

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;
    logic [AW-1:0]      w_raddr, w_waddr;
    logic               w_we;
    logic signed [31:0] w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end

    mroe_pkg::t_state r_state, n_state;
    logic [3:0]  r_op, n_op;
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_rows, n_rows, r_cols, n_cols;
    logic [3:0]  r_a, n_a, r_b, n_b;
    logic signed [31:0] r_val, n_val, r_t, n_t;
    logic [AW-1:0] r_clr, n_clr;
    logic [1:0]  r_stat, n_stat;
    logic signed [31:0] r_res, n_res;
    logic [SW-1:0] r_sum, n_sum, r_best, n_best;
    mroe_pkg::t_au_req w_req;
    mroe_pkg::t_au_rsp w_rsp;

    mroe_arith u_arith (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    function automatic logic [CW-1:0] eff(input logic [4:0] v);
        if (v == 5'd0) return CW'(1);
        if (32'(v) > MAX_DIM) return CW'(MAX_DIM);
        return CW'(v);
    endfunction

    function automatic logic [AW-1:0] adr(input logic [CW-1:0] r, input logic [CW-1:0] c);
        return AW'(32'(r[DW-1:0]) * MAX_DIM + 32'(c[DW-1:0]));
    endfunction

    logic [CW-1:0] w_ea, w_eb;
    logic [31:0]   w_vmag;
    logic [31:0]   w_emag;
    assign w_ea   = CW'(r_a);
    assign w_eb   = CW'(r_b);
    assign w_vmag = r_val[31] ? 32'(-r_val) : r_val;
    assign w_emag = r_rdata[31] ? 32'(-r_rdata) : r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mroe_pkg::S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
        r_op <= n_op; r_i <= n_i; r_j <= n_j; r_rows <= n_rows; r_cols <= n_cols;
        r_a <= n_a; r_b <= n_b; r_val <= n_val; r_t <= n_t; r_stat <= n_stat;
        r_res <= n_res; r_sum <= n_sum; r_best <= n_best;
    end

    // First and second element addresses of the current step.
    logic [AW-1:0] w_ad1, w_ad2;
    always_comb begin
        w_ad1 = adr(w_ea, r_j);
        w_ad2 = adr(w_eb, r_j);
        unique case (r_op)
            mroe_pkg::OP_TRANS: begin w_ad1 = adr(r_i, r_j); w_ad2 = adr(r_j, r_i); end
            mroe_pkg::OP_SWAPC: begin w_ad1 = adr(r_i, w_ea); w_ad2 = adr(r_i, w_eb); end
            mroe_pkg::OP_NORM:  begin w_ad1 = adr(r_i, r_j); w_ad2 = adr(r_i, r_j); end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state; n_op = r_op; n_i = r_i; n_j = r_j; n_rows = r_rows;
        n_cols = r_cols; n_a = r_a; n_b = r_b; n_val = r_val; n_t = r_t;
        n_clr = r_clr; n_stat = r_stat; n_res = r_res; n_sum = r_sum;
        n_best = r_best;
        w_we = 1'b0; w_waddr = w_ad1; w_wdata = r_t; w_raddr = w_ad1;
        w_req = '{start: 1'b0, op: mroe_pkg::AU_MUL, a: r_rdata, b: r_val};
        unique case (r_state)
            mroe_pkg::S_CLEAR: begin
                w_we = 1'b1; w_waddr = r_clr; w_wdata = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(DEPTH - 1)) n_state = mroe_pkg::S_IDLE;
            end
            mroe_pkg::S_IDLE: begin
                if (i_go) begin
                    n_op = i_op; n_a = i_index_a; n_b = i_index_b; n_val = i_value;
                    n_rows = eff(i_num_rows); n_cols = eff(i_num_cols);
                    n_i = '0; n_j = '0; n_stat = mroe_pkg::ST_OK; n_res = '0;
                    n_sum = '0; n_best = '0;
                    n_state = mroe_pkg::S_CALC;
                end
            end
            mroe_pkg::S_CALC: begin
                // validate and set up
                n_state = mroe_pkg::S_RD0;
                priority case (r_op)
                    mroe_pkg::OP_WRITE, mroe_pkg::OP_READ: begin
                        if (w_ea >= r_rows || w_eb >= r_cols) begin
                            n_stat = mroe_pkg::ST_BADIDX; n_state = mroe_pkg::S_RESP;
                        end else if (r_op == mroe_pkg::OP_WRITE) begin
                            w_we = 1'b1; w_waddr = adr(w_ea, w_eb); w_wdata = r_val;
                            n_state = mroe_pkg::S_RESP;
                        end else begin
                            n_j = w_eb;
                        end
                    end
                    mroe_pkg::OP_TRANS: begin
                        if (r_rows != r_cols) begin
                            n_stat = mroe_pkg::ST_NOTSQ; n_state = mroe_pkg::S_RESP;
                        end else n_state = mroe_pkg::S_NEXT;
                    end
                    mroe_pkg::OP_SWAPR, mroe_pkg::OP_ROWADD: begin
                        if (w_ea >= r_rows || w_eb >= r_rows) begin
                            n_stat = mroe_pkg::ST_BADIDX; n_state = mroe_pkg::S_RESP;
                        end
                    end
                    mroe_pkg::OP_SWAPC: begin
                        if (w_ea >= r_cols || w_eb >= r_cols) begin
                            n_stat = mroe_pkg::ST_BADIDX; n_state = mroe_pkg::S_RESP;
                        end
                    end
                    mroe_pkg::OP_SCALE: begin
                        if (w_ea >= r_rows) begin
                            n_stat = mroe_pkg::ST_BADIDX; n_state = mroe_pkg::S_RESP;
                        end
                    end
                    mroe_pkg::OP_DIVIDE: begin
                        if (w_ea >= r_rows) begin
                            n_stat = mroe_pkg::ST_BADIDX; n_state = mroe_pkg::S_RESP;
                        end else if (r_val == '0 || w_vmag < {1'b0, i_min_divisor}) begin
                            n_stat = mroe_pkg::ST_SMALL; n_state = mroe_pkg::S_RESP;
                        end
                    end
                    mroe_pkg::OP_NORM: ;
                    default: n_state = mroe_pkg::S_RESP;
                endcase
            end
            mroe_pkg::S_NEXT: begin
                // transpose: find next (i, j) with j > i
                if (r_j > r_i && r_j < r_cols) n_state = mroe_pkg::S_RD0;
                else if (r_j >= r_cols) begin
                    if (r_i + 1'b1 >= r_rows) n_state = mroe_pkg::S_RESP;
                    else begin n_i = r_i + 1'b1; n_j = r_i + 2'd2; end
                end else n_j = r_i + 1'b1;
            end
            mroe_pkg::S_RD0: begin
                w_raddr = (r_op == mroe_pkg::OP_ROWADD) ? w_ad2 : w_ad1;
                if (r_op == mroe_pkg::OP_READ) w_raddr = adr(w_ea, r_j);
                n_state = mroe_pkg::S_RD1;
            end
            mroe_pkg::S_RD1: begin
                // r_rdata holds first operand
                w_raddr = (r_op == mroe_pkg::OP_ROWADD) ? w_ad1 : w_ad2;
                n_t = r_rdata;
                priority case (r_op)
                    mroe_pkg::OP_READ: begin n_res = r_rdata; n_state = mroe_pkg::S_RESP; end
                    mroe_pkg::OP_NORM: begin
                        n_sum = r_sum + SW'(w_emag);
                        n_state = mroe_pkg::S_WR1;
                    end
                    mroe_pkg::OP_SCALE, mroe_pkg::OP_ROWADD: begin
                        w_req.start = 1'b1; n_state = mroe_pkg::S_AU;
                    end
                    mroe_pkg::OP_DIVIDE: begin
                        w_req.start = 1'b1; w_req.op = mroe_pkg::AU_DIV;
                        n_state = mroe_pkg::S_AU;
                    end
                    default: n_state = mroe_pkg::S_WAIT;
                endcase
            end
            mroe_pkg::S_WAIT: begin
                // swap: r_t = first, r_rdata = second
                w_we = 1'b1; w_waddr = w_ad1; w_wdata = r_rdata;
                n_state = mroe_pkg::S_WR0;
            end
            mroe_pkg::S_WR0: begin
                w_we = 1'b1; w_waddr = w_ad2; w_wdata = r_t;
                n_state = mroe_pkg::S_WR1;
            end
            mroe_pkg::S_AU: begin
                w_raddr = w_ad1;
                if (w_rsp.done) begin
                    w_we = 1'b1; w_waddr = w_ad1;
                    if (r_op == mroe_pkg::OP_ROWADD)
                        w_wdata = mroe_pkg::sat32(50'(r_rdata) + 50'(w_rsp.res));
                    else w_wdata = mroe_pkg::sat32(50'(w_rsp.res));
                    n_state = mroe_pkg::S_WR1;
                end
            end
            mroe_pkg::S_WR1: begin
                // advance walk
                if (r_op == mroe_pkg::OP_TRANS) begin
                    n_j = r_j + 1'b1; n_state = mroe_pkg::S_NEXT;
                end else if (r_op == mroe_pkg::OP_SWAPC) begin
                    n_i = r_i + 1'b1;
                    n_state = (r_i + 1'b1 >= r_rows) ? mroe_pkg::S_RESP : mroe_pkg::S_RD0;
                end else if (r_op == mroe_pkg::OP_NORM) begin
                    n_j = r_j + 1'b1; n_state = mroe_pkg::S_RD0;
                    if (r_j + 1'b1 >= r_cols) begin
                        if (r_sum > r_best) n_best = r_sum;
                        n_sum = '0; n_j = '0; n_i = r_i + 1'b1;
                        if (r_i + 1'b1 >= r_rows) begin
                            n_state = mroe_pkg::S_RESP;
                            n_res = ((r_sum > r_best ? r_sum : r_best) > SW'(32'h7fffffff))
                                ? mroe_pkg::SAT_MAX
                                : 32'(r_sum > r_best ? r_sum : r_best);
                        end
                    end
                end else begin
                    n_j = r_j + 1'b1;
                    n_state = (r_j + 1'b1 >= r_cols) ? mroe_pkg::S_RESP : mroe_pkg::S_RD0;
                end
            end
            mroe_pkg::S_RESP: begin
                if (!i_res_stall) n_state = mroe_pkg::S_IDLE;
            end
            default: n_state = mroe_pkg::S_IDLE;
        endcase
    end

    assign o_busy         = (r_state != mroe_pkg::S_IDLE);
    assign o_res_valid    = (r_state == mroe_pkg::S_RESP);
    assign o_status       = r_stat;
    assign o_result_value = r_res;
endmodule

// ===== rtl/core/matrix_row_operation_engine.sv =====
// Top level: APB register file and stream ports around the sequencer.
// Write/read touch one element; swaps, scale, row add and divide step through
// the elements (divide takes one quotient bit per cycle in the shared unit);
// transpose swaps each off-diagonal pair; norm visits all. One item at a time.
// Reset: synchronous; the store is cleared by a pass over every entry,
// during which no item is accepted. Registers reset to 16, 16, 1.
`timescale 1ns / 1ps
module matrix_row_operation_engine #(
    parameter int MAX_DIM = mroe_pkg::MAX_DIM_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [3:0]         i_op,
    input  logic [3:0]         i_index_a,
    input  logic [3:0]         i_index_b,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_result_value
);
    logic [4:0]  r_rows, r_cols;
    logic [30:0] r_mdiv;
    logic        w_busy;
    logic [1:0]  w_idx;
    assign w_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 5'd16;
            r_cols <= 5'd16;
            r_mdiv <= 31'd1;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                mroe_pkg::REG_ROWS: r_rows <= pwdata[4:0];
                mroe_pkg::REG_COLS: r_cols <= pwdata[4:0];
                mroe_pkg::REG_MDIV: r_mdiv <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            mroe_pkg::REG_ROWS: prdata = {27'd0, r_rows};
            mroe_pkg::REG_COLS: prdata = {27'd0, r_cols};
            mroe_pkg::REG_MDIV: prdata = {1'b0, r_mdiv};
            default:            prdata = '0;
        endcase
    end
    assign pready  = 1'b1;
    assign o_stall = w_busy;

    mroe_seq #(.MAX_DIM(MAX_DIM)) u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_go(i_valid && !w_busy), .o_busy(w_busy),
        .i_op(i_op), .i_index_a(i_index_a), .i_index_b(i_index_b), .i_value(i_value),
        .i_num_rows(r_rows), .i_num_cols(r_cols), .i_min_divisor(r_mdiv),
        .o_res_valid(o_valid), .i_res_stall(i_stall),
        .o_status(o_status), .o_result_value(o_result_value)
    );
endmodule

// ===== test/testbench.sv =====
// Testbench for the matrix row operation engine: stimulus, prediction and checking.
`timescale 1ns / 1ps
module testbench;
    import mroe_pkg::*;

    localparam int DIM = 16;
    localparam longint CYCLE_LIMIT = 10000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [3:0] i_op = '0, i_index_a = '0, i_index_b = '0;
    logic signed [31:0] i_value = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [1:0] o_status;
    logic signed [31:0] o_result_value;

    matrix_row_operation_engine uut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic signed [31:0] mat [DIM*DIM];
    logic [4:0] rows_reg, cols_reg;
    logic [30:0] min_div_reg;

    typedef struct packed {
        logic [1:0] status;
        logic signed [31:0] value;
    } t_outcome;
    t_outcome pending_q[$];

    int mismatches = 0;
    bit timed_out = 1'b0;
    bit quiet = 1'b0;      // no idling in the last part
    longint cycles = 0;

    function automatic int clip_dim(logic [4:0] v);
        if (v == 0) return 1;
        if (v > DIM) return DIM;
        return v;
    endfunction

    function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Q16.16 multiply: 64-bit product divided by 65536 (SV '/' truncates toward zero)
    function automatic logic signed [63:0] qprod(logic signed [31:0] a, logic signed [31:0] f);
        logic signed [63:0] p;
        p = 64'(a) * 64'(f);
        return p / 64'sd65536;
    endfunction

    function automatic t_outcome apply_op(logic [3:0] op, logic [3:0] a, logic [3:0] b,
                                          logic signed [31:0] v);
        t_outcome o;
        int nr, nc;
        logic signed [31:0] t;
        logic [31:0] mag;
        logic signed [63:0] s, best, e;
        nr = clip_dim(rows_reg);
        nc = clip_dim(cols_reg);
        o = '{status: ST_OK, value: '0};
        case (op)
            OP_WRITE, OP_READ: begin
                if (a >= nr || b >= nc) o.status = ST_BADIDX;
                else if (op == OP_WRITE) mat[a*DIM+b] = v;
                else o.value = mat[a*DIM+b];
            end
            OP_TRANS: begin
                if (nr != nc) o.status = ST_NOTSQ;
                else for (int i = 0; i < nr; i++)
                    for (int j = i + 1; j < nc; j++) begin
                        t = mat[i*DIM+j];
                        mat[i*DIM+j] = mat[j*DIM+i];
                        mat[j*DIM+i] = t;
                    end
            end
            OP_SWAPR: begin
                if (a >= nr || b >= nr) o.status = ST_BADIDX;
                else for (int j = 0; j < nc; j++) begin
                    t = mat[a*DIM+j]; mat[a*DIM+j] = mat[b*DIM+j]; mat[b*DIM+j] = t;
                end
            end
            OP_SWAPC: begin
                if (a >= nc || b >= nc) o.status = ST_BADIDX;
                else for (int i = 0; i < nr; i++) begin
                    t = mat[i*DIM+a]; mat[i*DIM+a] = mat[i*DIM+b]; mat[i*DIM+b] = t;
                end
            end
            OP_SCALE: begin
                if (a >= nr) o.status = ST_BADIDX;
                else for (int j = 0; j < nc; j++)
                    mat[a*DIM+j] = clamp32(qprod(mat[a*DIM+j], v));
            end
            OP_DIVIDE: begin
                mag = v[31] ? -v : v;
                if (a >= nr) o.status = ST_BADIDX;
                else if (v == 0 || mag < {1'b0, min_div_reg}) o.status = ST_SMALL;
                else for (int j = 0; j < nc; j++)
                    mat[a*DIM+j] = clamp32((64'(mat[a*DIM+j]) * 64'sd65536) / 64'(v));
            end
            OP_ROWADD: begin
                if (a >= nr || b >= nr) o.status = ST_BADIDX;
                else for (int j = 0; j < nc; j++)
                    mat[a*DIM+j] = clamp32(64'(mat[a*DIM+j]) + qprod(mat[b*DIM+j], v));
            end
            OP_NORM: begin
                best = 0;
                for (int i = 0; i < nr; i++) begin
                    s = 0;
                    for (int j = 0; j < nc; j++) begin
                        e = 64'(mat[i*DIM+j]);
                        s += (e < 0) ? -e : e;
                    end
                    if (s > best) best = s;
                end
                o.value = clamp32(best);
            end
            default: ;
        endcase
        return o;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stall bursts, check each transaction
    initial begin
        int n;
        t_outcome exp_o;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result status=%0d value=%0h",
                                                   o_status, o_result_value);
                end else begin
                    exp_o = pending_q.pop_front();
                    if (o_status !== exp_o.status || o_result_value !== exp_o.value) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp status=%0d value=%0h, got status=%0d value=%0h",
                                     exp_o.status, exp_o.value, o_status, o_result_value);
                    end
                end
            end
            if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 18);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                // checks for edges skipped while stalled are not needed: stall was high
                i_stall <= 1'b0;
            end
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_ROWS: rows_reg = data[4:0];
            REG_COLS: cols_reg = data[4:0];
            REG_MDIV: min_div_reg = data[30:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);  // settle before any register change
    endtask

    task automatic send_item(t_op op, logic [3:0] a, logic [3:0] b, logic signed [31:0] v);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid <= 1'b1; i_op <= op; i_index_a <= a; i_index_b <= b; i_value <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_q.push_back(apply_op(op, a, b, v));
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_item(OP_WRITE, 0, 0, 32'sh7fffffff);
        send_item(OP_WRITE, 15, 15, 32'sh80000000);
        send_item(OP_WRITE, 0, 15, 32'sh00018000);
        send_item(OP_READ, 15, 15, 0);
        send_item(OP_NORM, 0, 0, 0);
        send_item(OP_TRANS, 0, 0, 0);
        send_item(OP_READ, 15, 0, 0);
        send_item(OP_SWAPR, 0, 15, 0);
        send_item(OP_SWAPR, 3, 3, 0);
        send_item(OP_SWAPC, 0, 15, 0);
        send_item(OP_SCALE, 15, 0, 32'sh7fffffff);
        send_item(OP_DIVIDE, 0, 0, 32'sh00000001);
        send_item(OP_DIVIDE, 0, 0, 0);
        send_item(OP_DIVIDE, 0, 0, 32'sh80000000);
        send_item(OP_ROWADD, 15, 15, 32'sh80000000);
        send_item(OP_ROWADD, 0, 15, 32'sh00010000);
        send_item(OP_NORM, 0, 0, 0);
        send_item(t_op'(4'd9), 0, 0, 0);
        send_item(t_op'(4'd15), 15, 15, -1);
        drain();
        reg_write(REG_ROWS, 3);
        reg_write(REG_COLS, 2);
        reg_write(REG_MDIV, 32'h0001_0000);
        send_item(OP_TRANS, 0, 0, 0);
        send_item(OP_READ, 3, 0, 0);
        send_item(OP_WRITE, 0, 2, 5);
        send_item(OP_SWAPC, 0, 2, 0);
        send_item(OP_DIVIDE, 5, 0, 32'sh0000ffff);
        send_item(OP_DIVIDE, 1, 0, 32'shffff0001);
        drain();
    endtask

    task automatic test_random(int count, logic [4:0] r, logic [4:0] c, logic [31:0] md);
        int nr, nc, k;
        t_op op;
        reg_write(REG_ROWS, {$urandom} & 32'hffff_ffe0 | r);
        reg_write(REG_COLS, c);
        reg_write(REG_MDIV, md);
        nr = clip_dim(r);
        nc = clip_dim(c);
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 19);
            // mostly in-range indices; divide (slow) kept rare
            if (k < 6) op = OP_WRITE;
            else if (k < 8) op = OP_READ;
            else if (k == 8) op = OP_TRANS;
            else if (k == 9) op = OP_SWAPR;
            else if (k == 10) op = OP_SWAPC;
            else if (k < 13) op = OP_SCALE;
            else if (k == 13) op = OP_DIVIDE;
            else if (k < 16) op = OP_ROWADD;
            else if (k < 18) op = OP_NORM;
            else op = t_op'($urandom_range(0, 15));
            if ($urandom_range(0, 9) == 0)
                send_item(op, 4'($urandom), 4'($urandom), rand_value());
            else
                send_item(op, 4'($urandom_range(0, DIM - 1) % (op == OP_SWAPC ? nc : nr)),
                          4'($urandom_range(0, DIM - 1) % ((op == OP_WRITE || op == OP_READ ||
                           op == OP_SWAPC) ? nc : nr)), rand_value());
        end
        drain();
    endtask

    task automatic test_wait_for_results();
        send_item(OP_NORM, 0, 0, 0);
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        send_item(OP_READ, 0, 0, 0);
        drain();
    endtask

    initial begin
        for (int i = 0; i < DIM*DIM; i++) mat[i] = '0;
        rows_reg = 5'd16; cols_reg = 5'd16; min_div_reg = 31'd1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(200, 4, 4, 32'h0000_4000);
        test_random(150, 16, 16, 1);
        test_wait_for_results();
        test_random(150, 1, 16, 0);
        test_random(150, 0, 31, 32'h7fff_ffff);
        test_random(150, 5, 3, 32'h0000_0100);
        quiet = 1'b1;
        test_random(150, 8, 8, 1);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
